FILE: src/pid_deadzone_antiwindup_assert.svh
// Assertion helpers used by the controller core (pda_core).
`ifndef PID_DEADZONE_ANTIWINDUP_ASSERT_SVH
`define PID_DEADZONE_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication.
`define PDA_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid assertion failed");

// Next-cycle implication.
`define PDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid assertion failed");

`endif

FILE: src/pda_pkg.sv
`default_nettype none
package pda_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 16;
  localparam int LIM_W       = 16;
  localparam int ERR_W       = SAMPLE_BITS + 1;
  localparam int DERIV_W     = ERR_W + 1;
  localparam int INTEG_W     = LIM_W + 1;
  localparam int CAND_W      = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
  localparam int DRIVE_W     = LIM_W + 1;
  localparam int PROD_P_W    = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W    = GAIN_W + 1 + INTEG_W;
  localparam int PROD_D_W    = GAIN_W + 1 + DERIV_W;
  localparam int SUM_W       = PROD_D_W + 1;
  localparam int FRAC_BITS   = 8;
  localparam int VAL_W       = SUM_W - FRAC_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_DEAD_BAND   = 3'd5,
    REG_WINDUP_MODE = 3'd6
  } pda_reg_idx_t;

  localparam logic [GAIN_W-1:0] RST_GAIN_PROP   = 16'd10240;
  localparam logic [GAIN_W-1:0] RST_GAIN_INTEG  = 16'd1152;
  localparam logic [GAIN_W-1:0] RST_GAIN_DERIV  = 16'd1280;
  localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT = 16'd400;
  localparam logic [LIM_W-1:0]  RST_OUT_LIMIT   = 16'd1000;
  localparam logic [LIM_W-1:0]  RST_DEAD_BAND   = 16'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [LIM_W-1:0]  integ_limit;
    logic [LIM_W-1:0]  out_limit;
    logic [LIM_W-1:0]  dead_band;
    logic              windup_mode;
  } pda_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] setpoint;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic                          clear;
  } pda_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } pda_out_t;

endpackage
`default_nettype wire

FILE: src/pid_deadzone_antiwindup.sv
// PID speed controller with dead band and selectable anti-windup.
// Input channel (in_valid/in_stall/in_data): one sample per transaction,
//   setpoint and measured (signed) plus a clear flag.
// Output channel (out_valid/out_stall/out_data): one result per input,
//   the clamped drive value and a clamped flag, in input order.
// Config port: cfg_we with cfg_index/cfg_wdata writes one register per cycle;
//   write only while no transaction is in flight. Unmapped indexes are ignored.
// Path: a sample is held in the input register, then in the result register,
//   and out_valid rises once it reaches the result register.
// Rate: one transaction per cycle while not stalled; the integrator loop
//   is combinational: integ_sum, clamp, multiply, output clamp, commit.
// Reset (rst, synchronous): gains and limits return to defaults, integrator
//   and previous error clear, both pipeline stages empty.
// Receiver stall: the result register holds; the input register keeps its
//   item and in_stall rises only once both stages are full.
// A clear transaction zeroes the controller state and returns drive 0.
`default_nettype none
module pid_deadzone_antiwindup
  import pda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pda_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pda_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  pda_cfg_t cfg;
  pda_in_t  in_q;
  logic     in_q_valid;
  pda_out_t res;
  logic     res_ready;
  logic     fire;

  assign res_ready = !out_valid || !out_stall;
  assign fire      = in_q_valid && res_ready;
  assign in_stall  = in_q_valid && !res_ready;

  pda_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pda_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .item (in_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (res_ready) begin
        out_valid <= in_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (fire) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/pda_cfg.sv
`default_nettype none
module pda_cfg
  import pda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output pda_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop   <= RST_GAIN_PROP;
      cfg.gain_integ  <= RST_GAIN_INTEG;
      cfg.gain_deriv  <= RST_GAIN_DERIV;
      cfg.integ_limit <= RST_INTEG_LIMIT;
      cfg.out_limit   <= RST_OUT_LIMIT;
      cfg.dead_band   <= RST_DEAD_BAND;
      cfg.windup_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   cfg.gain_prop   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg.gain_integ  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg.gain_deriv  <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= cfg_wdata[LIM_W-1:0];
        REG_OUT_LIMIT:   cfg.out_limit   <= cfg_wdata[LIM_W-1:0];
        REG_DEAD_BAND:   cfg.dead_band   <= cfg_wdata[LIM_W-1:0];
        REG_WINDUP_MODE: cfg.windup_mode <= cfg_wdata[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/pda_core.sv
`default_nettype none
`include "pid_deadzone_antiwindup_assert.svh"
module pda_core
  import pda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire pda_cfg_t cfg,
  input  wire pda_in_t  item,
  output pda_out_t      res
);

  logic signed [ERR_W-1:0]    last_error;
  logic signed [INTEG_W-1:0]  integ_sum;

  logic signed [ERR_W-1:0]    err;
  logic signed [DERIV_W-1:0]  deriv;
  logic signed [CAND_W-1:0]   cand_raw;
  logic signed [CAND_W-1:0]   ilim_pos;
  logic signed [CAND_W-1:0]   ilim_neg;
  logic signed [INTEG_W-1:0]  cand;
  logic signed [ERR_W-1:0]    db_pos;
  logic signed [ERR_W-1:0]    db_neg;
  logic                       outside_band;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [VAL_W-1:0]    val;
  logic signed [VAL_W-1:0]    olim_pos;
  logic signed [VAL_W-1:0]    olim_neg;
  logic                       hi;
  logic                       lo;
  logic                       commit;
  logic signed [DRIVE_W-1:0]  drv;

  always_comb begin
    err      = ERR_W'(item.setpoint) - ERR_W'(item.measured);
    deriv    = DERIV_W'(err) - DERIV_W'(last_error);

    cand_raw = CAND_W'(integ_sum) + CAND_W'(err);
    ilim_pos = signed'(CAND_W'(cfg.integ_limit));
    ilim_neg = -ilim_pos;
    if (cand_raw > ilim_pos) begin
      cand = INTEG_W'(ilim_pos);
    end else if (cand_raw < ilim_neg) begin
      cand = INTEG_W'(ilim_neg);
    end else begin
      cand = INTEG_W'(cand_raw);
    end

    db_pos       = signed'(ERR_W'(cfg.dead_band));
    db_neg       = -db_pos;
    outside_band = (err > db_pos) || (err < db_neg);

    prod_p = signed'({1'b0, cfg.gain_prop})  * err;
    prod_i = signed'({1'b0, cfg.gain_integ}) * cand;
    prod_d = signed'({1'b0, cfg.gain_deriv}) * deriv;

    sum = SUM_W'(prod_i);
    if (outside_band) begin
      sum = sum + SUM_W'(prod_p) + SUM_W'(prod_d);
    end
    // arithmetic shift floors negative sums
    val = VAL_W'(sum >>> FRAC_BITS);

    olim_pos = signed'(VAL_W'(cfg.out_limit));
    olim_neg = -olim_pos;
    hi  = val > olim_pos;
    lo  = val < olim_neg;
    if (hi) begin
      drv = DRIVE_W'(olim_pos);
    end else if (lo) begin
      drv = DRIVE_W'(olim_neg);
    end else begin
      drv = DRIVE_W'(val);
    end

    if (!hi && !lo) begin
      commit = 1'b1;
    end else if (cfg.windup_mode) begin
      // only let the integrator move back toward the unclamped region
      commit = (hi && err < 0) || (lo && err > 0);
    end else begin
      commit = 1'b0;
    end

    if (item.clear) begin
      res.drive   = '0;
      res.clamped = 1'b0;
    end else begin
      res.drive   = drv;
      res.clamped = hi || lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integ_sum  <= '0;
    end else if (fire) begin
      if (item.clear) begin
        last_error <= '0;
        integ_sum  <= '0;
      end else begin
        last_error <= err;
        if (commit) begin
          integ_sum <= cand;
        end
      end
    end
  end

  `PDA_ASSERT(clamp_at_limit, clk, rst, fire && res.clamped,
    (res.drive == DRIVE_W'(olim_pos) || res.drive == DRIVE_W'(olim_neg)))
  `PDA_ASSERT_NEXT(clear_zeroes_state, clk, rst, fire && item.clear,
    (integ_sum == '0 && last_error == '0))
  `PDA_ASSERT_NEXT(mode0_holds_integ, clk, rst,
    fire && !item.clear && res.clamped && !cfg.windup_mode,
    integ_sum == $past(integ_sum))
  `PDA_ASSERT_NEXT(error_tracked, clk, rst, fire && !item.clear,
    last_error == $past(err))

endmodule
`default_nettype wire

FILE: tb/sv/pid_deadzone_antiwindup_tb.sv
`timescale 1ns / 100ps
module pid_deadzone_antiwindup_tb;
  import pda_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 55;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    pda_in_t                smp;
    bit                     typed;
    pda_out_t               want;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pda_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pda_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pid_deadzone_antiwindup dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // controller copy: configuration and state
  pda_cfg_t          ctrl_cfg;
  logic signed [17:0] prev_err;
  logic signed [17:0] integ_acc;

  pda_out_t drive_q[$];
  pda_out_t head_exp;
  dir_row_t dir_tbl[$];
  int       bad_results = 0;
  int       idle_cycles = 0;
  int       hold = 0;
  bit       calm = 1'b0;

  function automatic pda_out_t calc_drive(pda_in_t s);
    logic signed [17:0] err;
    logic signed [17:0] deriv;
    logic signed [18:0] cand;
    longint lim, olim, db, sum, val;
    bit hi, lo, commit;
    pda_out_t r;
    r = '0;
    hi = 1'b0;
    lo = 1'b0;
    if (s.clear) begin
      prev_err = '0;
      integ_acc = '0;
      return r;
    end
    err = {{2{s.setpoint[15]}}, s.setpoint} - {{2{s.measured[15]}}, s.measured};
    deriv = err - prev_err;
    prev_err = err;
    lim = longint'(ctrl_cfg.integ_limit);
    cand = {integ_acc[17], integ_acc} + {err[17], err};
    if (longint'(cand) > lim) cand = lim[18:0];
    else if (longint'(cand) < -lim) cand = 19'(-lim);
    db = longint'(ctrl_cfg.dead_band);
    sum = longint'(ctrl_cfg.gain_integ) * longint'(cand);
    if (longint'(err) > db || longint'(err) < -db)
      sum += longint'(ctrl_cfg.gain_prop) * longint'(err)
           + longint'(ctrl_cfg.gain_deriv) * longint'(deriv);
    val = sum >>> 8;  // floor toward minus infinity
    olim = longint'(ctrl_cfg.out_limit);
    if (val > olim) begin
      val = olim;
      hi = 1'b1;
    end else if (val < -olim) begin
      val = -olim;
      lo = 1'b1;
    end
    if (!hi && !lo) commit = 1'b1;
    else if (ctrl_cfg.windup_mode) commit = (hi && err < 0) || (lo && err > 0);
    else commit = 1'b0;
    if (commit) integ_acc = cand[17:0];
    r.drive = val[DRIVE_W-1:0];
    r.clamped = hi | lo;
    return r;
  endfunction

  function automatic dir_row_t smp(int sp, int ms, bit clr);
    dir_row_t row;
    row = '{default: '0, kind: ROW_SAMPLE};
    row.smp.setpoint = sp[15:0];
    row.smp.measured = ms[15:0];
    row.smp.clear = clr;
    return row;
  endfunction

  function automatic dir_row_t smp_x(int sp, int ms, bit clr, int drv, bit clp);
    dir_row_t row;
    row = smp(sp, ms, clr);
    row.typed = 1'b1;
    row.want.drive = drv[DRIVE_W-1:0];
    row.want.clamped = clp;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
    dir_row_t row;
    row = '{default: '0, kind: ROW_CFG};
    row.idx = idx;
    row.data = data[15:0];
    return row;
  endfunction

  function automatic logic [15:0] pick16(int typ_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, typ_max));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN_PROP:   ctrl_cfg.gain_prop = data;
      REG_GAIN_INTEG:  ctrl_cfg.gain_integ = data;
      REG_GAIN_DERIV:  ctrl_cfg.gain_deriv = data;
      REG_INTEG_LIMIT: ctrl_cfg.integ_limit = data;
      REG_OUT_LIMIT:   ctrl_cfg.out_limit = data;
      REG_DEAD_BAND:   ctrl_cfg.dead_band = data;
      REG_WINDUP_MODE: ctrl_cfg.windup_mode = data[0];
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic drive_sample(pda_in_t s, bit typed, pda_out_t want);
    int gap;
    pda_out_t exp_r;
    gap = calm ? 0 : $urandom_range(0, 4);
    cfg_we <= 1'b0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_r = calc_drive(s);
    drive_q.push_back(typed ? want : exp_r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver side, result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("pid_deadzone_antiwindup: mismatch");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          if (drive_q.size() == 0) begin
            $error("unexpected result transaction: drive %0d", out_data.drive);
            bad_results++;
          end else begin
            head_exp = drive_q.pop_front();
            if (out_data.drive !== head_exp.drive) begin
              $error("drive: expected %0d, got %0d", head_exp.drive, out_data.drive);
              bad_results++;
            end
            if (out_data.clamped !== head_exp.clamped) begin
              $error("clamped: expected %0d, got %0d", head_exp.clamped,
                     out_data.clamped);
              bad_results++;
            end
          end
          hold = calm ? 0 : $urandom_range(0, 4);
        end else if (hold > 0) begin
          hold--;
        end
        out_stall <= (hold > 0);
      end
    end
  end

  initial begin
    pda_in_t s;
    logic signed [15:0] tgt;
    int span, e, m, r;

    ctrl_cfg = '{gain_prop: RST_GAIN_PROP, gain_integ: RST_GAIN_INTEG,
                 gain_deriv: RST_GAIN_DERIV, integ_limit: RST_INTEG_LIMIT,
                 out_limit: RST_OUT_LIMIT, dead_band: RST_DEAD_BAND,
                 windup_mode: 1'b0};
    prev_err = '0;
    integ_acc = '0;

    // reset values
    dir_tbl.push_back(smp_x(32767, -32768, 1, 0, 0));
    dir_tbl.push_back(smp_x(0, 0, 0, 0, 0));
    dir_tbl.push_back(smp_x(32767, -32768, 0, 1000, 1));
    dir_tbl.push_back(smp_x(-32768, 32767, 0, -1000, 1));
    dir_tbl.push_back(smp_x(0, 0, 1, 0, 0));
    // dead band edges and negative rounding
    dir_tbl.push_back(smp(2, 0, 0));
    dir_tbl.push_back(smp(0, 2, 0));
    dir_tbl.push_back(smp(0, 3, 0));
    dir_tbl.push_back(smp(100, 90, 0));
    dir_tbl.push_back(smp(-1, 0, 0));
    // max gains
    dir_tbl.push_back(cfg_row(REG_GAIN_PROP, 65535));
    dir_tbl.push_back(cfg_row(REG_GAIN_INTEG, 65535));
    dir_tbl.push_back(cfg_row(REG_GAIN_DERIV, 65535));
    dir_tbl.push_back(smp_x(32767, -32768, 0, 1000, 1));
    // zero limits: clamped only when the shifted sum is nonzero
    dir_tbl.push_back(cfg_row(REG_INTEG_LIMIT, 0));
    dir_tbl.push_back(cfg_row(REG_OUT_LIMIT, 0));
    dir_tbl.push_back(smp_x(5, 0, 0, 0, 1));
    dir_tbl.push_back(smp_x(0, 0, 1, 0, 0));
    dir_tbl.push_back(smp_x(0, 0, 0, 0, 0));
    dir_tbl.push_back(smp_x(1, 0, 0, 0, 0));
    // write to an unmapped index must be dropped
    dir_tbl.push_back(cfg_row(REG_UNMAPPED, 16'h1234));
    dir_tbl.push_back(smp(0, 1, 0));
    // anti-windup toward unclamping, driven through the derivative term
    dir_tbl.push_back(cfg_row(REG_GAIN_PROP, 0));
    dir_tbl.push_back(cfg_row(REG_GAIN_INTEG, 256));
    dir_tbl.push_back(cfg_row(REG_GAIN_DERIV, 256));
    dir_tbl.push_back(cfg_row(REG_INTEG_LIMIT, 1000));
    dir_tbl.push_back(cfg_row(REG_OUT_LIMIT, 100));
    dir_tbl.push_back(cfg_row(REG_DEAD_BAND, 0));
    dir_tbl.push_back(cfg_row(REG_WINDUP_MODE, 1));
    dir_tbl.push_back(smp(0, 0, 1));
    dir_tbl.push_back(smp(-200, 0, 0));
    dir_tbl.push_back(smp(-1, 0, 0));
    dir_tbl.push_back(smp(200, 0, 0));
    dir_tbl.push_back(smp(1, 0, 0));
    dir_tbl.push_back(smp(0, 0, 0));
    dir_tbl.push_back(cfg_row(REG_WINDUP_MODE, 0));
    dir_tbl.push_back(smp(-200, 0, 0));
    dir_tbl.push_back(smp(-1, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        drive_sample(dir_tbl[i].smp, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    tgt = '0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_GAIN_PROP, pick16(3000));
      write_reg(REG_GAIN_INTEG, pick16(3000));
      write_reg(REG_GAIN_DERIV, pick16(3000));
      write_reg(REG_INTEG_LIMIT, pick16(2000));
      write_reg(REG_OUT_LIMIT, pick16(2000));
      write_reg(REG_DEAD_BAND, pick16(30));
      write_reg(REG_WINDUP_MODE, 16'($urandom));
      case ($urandom_range(0, 3))
        0: span = 3;
        1: span = 50;
        2: span = 300;
        default: span = 5000;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        s = '0;
        r = $urandom_range(0, 99);
        if (r < 3) begin
          s.clear = 1'b1;
          s.setpoint = 16'($urandom);
          s.measured = 16'($urandom);
        end else if (r < 13) begin
          s.setpoint = 16'($urandom);
          s.measured = 16'($urandom);
        end else begin
          // tracking: target held for a while, measurement close to it
          if ($urandom_range(0, 19) == 0) tgt = 16'($urandom);
          e = int'($urandom_range(0, 2 * span)) - span;
          m = int'(tgt) - e;
          if (m > 32767) m = 32767;
          else if (m < -32768) m = -32768;
          s.setpoint = tgt;
          s.measured = m[15:0];
        end
        drive_sample(s, 1'b0, '0);
      end
    end

    settle();
    if (bad_results == 0 && drive_q.size() == 0)
      $display("pid_deadzone_antiwindup: match");
    else
      $display("pid_deadzone_antiwindup: mismatch");
    $finish;
  end

endmodule
